/* hdl/dlrb_pkg.sv */
// ============================================================================
// dlrb_pkg
// Shared types and constants for the delimited line ring buffer.
// ============================================================================
package dlrb_pkg;

    // byte width of stored and emitted data
    localparam int BYTE_W = 8;

    // delimiter after reset (line feed)
    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd10;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // command kinds decoded from func
    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } cmd_kind_t;

    // one queued command
    typedef struct packed {
        cmd_kind_t          kind;
        logic [BYTE_W-1:0]  data;
    } cmd_t;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_MISS
    } back_state_t;

endpackage

/* hdl/dlrb_ifs.sv */
// ============================================================================
// dlrb_ifs
// Channel interfaces: command input, line output and delimiter write.
// ============================================================================

// command input channel
interface dlrb_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

// line byte output channel
interface dlrb_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output found, output out_byte, output last,
                    input ready);
    modport sink   (input valid, input found, input out_byte, input last,
                    output ready);
endinterface

// delimiter register write channel
interface dlrb_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/dlrb_front.sv */
// ============================================================================
// dlrb_front
// Accepts input words, decodes the command and queues it for the back end.
// ============================================================================
module dlrb_front
    import dlrb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dlrb_in_if.sink     in_ch,
    input  logic        pop,
    output cmd_head_t   head
);

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop_ok;
    cmd_t              cmd_in;

    // decode the incoming word
    always_comb
    begin
        cmd_in.kind = in_ch.func ? CMD_READ : CMD_WRITE;
        cmd_in.data = in_ch.data_byte;
    end

    assign in_ch.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign pop_ok      = pop && (count_reg != '0);

    // queue pointers and fill
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = tail_reg + 1'b1;
        end
        if (pop_ok)
        begin
            head_next = head_reg + 1'b1;
        end
        if (push && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[tail_reg] <= cmd_in;
        end
    end

    always_comb
    begin
        head.valid = (count_reg != '0);
        head.cmd   = entries_reg[head_reg];
    end

endmodule

/* hdl/dlrb_back.sv */
// ============================================================================
// dlrb_back
// Executes queued commands on the byte store: appends bytes, scans for the
// delimiter and streams out the extracted line or a miss word.
// ============================================================================
module dlrb_back
    import dlrb_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_head_t   head,
    output logic        pop,
    dlrb_cfg_if.sink    cfg,
    dlrb_out_if.source  out_ch
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // byte store and its registered read port
    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    back_state_t       state_reg, state_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] delim_reg;

    logic              out_valid_reg;
    logic              out_found_reg, out_found_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_load;
    logic              out_free;

    logic              mem_we;
    logic              mem_re;
    logic [PTR_W-1:0]  mem_raddr;
    logic [CNT_W-1:0]  cnt_inc;

    // circular increment
    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign out_free = !out_valid_reg || out_ch.ready;

    // sequencer: next state and datapath controls
    always_comb
    begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = ptr_reg;
        out_load       = 1'b0;
        out_found_next = 1'b0;
        out_byte_next  = '0;
        out_last_next  = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.cmd.kind == CMD_WRITE)
                    begin
                        mem_we      = 1'b1;
                        wr_ptr_next = wrap_inc(wr_ptr_reg);
                        // full: drop the oldest byte
                        if (fill_reg == CNT_W'(DEPTH))
                        begin
                            rd_ptr_next = wrap_inc(rd_ptr_reg);
                        end
                        else
                        begin
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = ST_MISS;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = rd_ptr_reg;
                        ptr_next   = wrap_inc(rd_ptr_reg);
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // rdata_reg holds the byte at offset cnt_reg
                if (rdata_reg == delim_reg)
                begin
                    len_next   = cnt_inc;
                    mem_re     = 1'b1;
                    mem_raddr  = rd_ptr_reg;
                    ptr_next   = wrap_inc(rd_ptr_reg);
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else if (cnt_inc == fill_reg)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg;
                    ptr_next  = wrap_inc(ptr_reg);
                    cnt_next  = cnt_inc;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_found_next = 1'b1;
                    out_byte_next  = rdata_reg;
                    out_last_next  = (cnt_inc == len_reg);
                    if (cnt_inc == len_reg)
                    begin
                        // ptr_reg already points past the delimiter
                        rd_ptr_next = ptr_reg;
                        fill_next   = fill_reg - len_reg;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_reg;
                        ptr_next  = wrap_inc(ptr_reg);
                        cnt_next  = cnt_inc;
                    end
                end
            end

            ST_MISS:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
            ptr_reg    <= '0;
            cnt_reg    <= '0;
            len_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
            ptr_reg    <= ptr_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
        end
    end

    // byte store: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= head.cmd.data;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // delimiter register, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_RESET;
        end
        else if (cfg.valid)
        begin
            delim_reg <= cfg.data;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_found_reg <= out_found_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.found    = out_found_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.last     = out_last_reg;

endmodule

/* hdl/delimited_line_ring_buffer.sv */
// ============================================================================
// delimited_line_ring_buffer
// Byte ring buffer that hands out whole delimiter-terminated lines.
// ============================================================================
// Writes: one byte per cycle sustained while no read is in progress; a
//   4-entry command queue sits in front.
// Reads: the read word is popped, then the store is scanned from the oldest
//   byte for the delimiter; a complete line is emitted byte by byte, stalling
//   while the output is held, else a single miss word is sent.
// Reset: pointers, count, queue clear, delimiter to 10; store left as is.
module delimited_line_ring_buffer
    import dlrb_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    dlrb_in_if.sink     in_ch,
    dlrb_cfg_if.sink    cfg,
    dlrb_out_if.source  out_ch
);

    cmd_head_t head;
    logic      pop;

    dlrb_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .pop   (pop),
        .head  (head)
    );

    dlrb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .cfg    (cfg),
        .out_ch (out_ch)
    );

endmodule

/* hdl/dlrb_checker.sv */
// ============================================================================
// dlrb_checker
// Port-level checks on the line output stream, bound to the top level.
// ============================================================================
module dlrb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_found,
    input logic [7:0] out_byte,
    input logic       out_last
);

    // set while a line has started but its last byte is not yet taken
    logic mid_line_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_line_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            mid_line_reg <= out_found && !out_last;
        end
    end

    // a miss is a single, final word
    a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_found |-> out_last)
        else $error("miss result without last");

    // a miss carries a zero byte
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_found |-> out_byte == 8'd0)
        else $error("miss result with nonzero byte");

    // no miss in the middle of a line
    a_line_continues: assert property (@(posedge clk) disable iff (!rst_n)
        mid_line_reg && out_valid |-> out_found)
        else $error("line interrupted by a miss");

    // stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_found)
            && $stable(out_byte) && $stable(out_last))
        else $error("output changed while stalled");

endmodule

bind delimited_line_ring_buffer dlrb_checker u_dlrb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_found (out_ch.found),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last)
);

/* bench/tb_top.sv */
// ============================================================================
// tb_top
// Testbench for the delimited line ring buffer: a local line predictor
// tracks the byte ring and the delimiter, every output word is checked in
// order against it, under random idling, a long output hold-off and
// buffer overwrite.
// ============================================================================
module tb_top;
    import dlrb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 64;
    localparam int SETTLE_CYCLES  = 16;     // queued writes still in flight
    localparam int TAIL_CYCLES    = 50;
    localparam int HOLD_LEN       = 200;    // long output hold-off
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;

    // one expected output word
    typedef struct packed {
        logic              found;
        logic [BYTE_W-1:0] byte_val;
        logic              last;
    } line_word_t;

    logic clk = 1'b0;
    logic rst_n;

    dlrb_in_if  in_if ();
    dlrb_out_if out_if ();
    dlrb_cfg_if cfg_if ();

    delimited_line_ring_buffer #(.DEPTH(DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .cfg    (cfg_if),
        .out_ch (out_if)
    );

    always #5 clk = ~clk;

    // line predictor state
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    int unsigned       rd_ptr;
    int unsigned       wr_ptr;
    int unsigned       fill_level;
    logic [BYTE_W-1:0] delim_reg;
    line_word_t        line_words_q [$];

    // traffic shaping
    int send_idle_pct;
    int sink_stall_pct;
    int hold_requests;
    int mismatch_count;

    // apply one accepted command to the ring, queue the words it yields
    function automatic void apply_command(input cmd_kind_t kind,
                                          input logic [BYTE_W-1:0] b);
        int unsigned p;
        int unsigned span;
        line_word_t  w;
        if (kind == CMD_WRITE)
        begin
            ring_mem[wr_ptr] = b;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            // full: oldest byte is overwritten
            if (fill_level == DEPTH)
                rd_ptr = (rd_ptr + 1) % DEPTH;
            else
                fill_level++;
            return;
        end
        span = 0;
        p = rd_ptr;
        for (int i = 0; i < fill_level; i++)
        begin
            if (ring_mem[p] == delim_reg)
            begin
                span = i + 1;
                break;
            end
            p = (p + 1) % DEPTH;
        end
        // no complete line: single miss word, state untouched
        if (span == 0)
        begin
            w.found    = 1'b0;
            w.byte_val = '0;
            w.last     = 1'b1;
            line_words_q.push_back(w);
            return;
        end
        for (int i = 0; i < span; i++)
        begin
            w.found    = 1'b1;
            w.byte_val = ring_mem[rd_ptr];
            w.last     = (i == span - 1);
            line_words_q.push_back(w);
            rd_ptr = (rd_ptr + 1) % DEPTH;
        end
        fill_level -= span;
    endfunction

    // send one command word; valid stays high on return
    task automatic send_cmd(input cmd_kind_t kind, input logic [BYTE_W-1:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.func      <= kind;
        in_if.data_byte <= b;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        apply_command(kind, b);
    endtask

    task automatic read_line();
        send_cmd(CMD_READ, BYTE_W'($urandom_range(255)));
    endtask

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(255));
        while (b == delim_reg);
        return b;
    endfunction

    // len-1 ordinary bytes followed by the delimiter
    task automatic send_line(input int len);
        for (int i = 0; i < len - 1; i++)
            send_cmd(CMD_WRITE, plain_byte());
        send_cmd(CMD_WRITE, delim_reg);
    endtask

    // sender pauses until every expected word has come
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (line_words_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_delimiter(input logic [BYTE_W-1:0] v);
        wait_drain();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        delim_reg = v;
        cfg_if.valid <= 1'b0;
    endtask

    // empty reads, bit extremes, lines and misses at the reset delimiter
    task automatic test_basic_lines();
        send_idle_pct = 0;
        read_line();
        send_cmd(CMD_WRITE, 8'h00);
        send_cmd(CMD_WRITE, 8'hFF);
        send_cmd(CMD_WRITE, 8'h55);
        send_cmd(CMD_WRITE, 8'hAA);
        send_cmd(CMD_WRITE, DELIM_RESET);
        read_line();
        send_cmd(CMD_WRITE, 8'h41);
        read_line();
        send_cmd(CMD_WRITE, DELIM_RESET);
        send_cmd(CMD_WRITE, DELIM_RESET);
        read_line();
        read_line();
        read_line();
        wait_drain();
    endtask

    // delimiter at both ends of its range
    task automatic test_delimiter_extremes();
        set_delimiter(8'h00);
        send_cmd(CMD_WRITE, 8'hFF);
        send_cmd(CMD_WRITE, 8'h00);
        read_line();
        read_line();
        set_delimiter(8'hFF);
        send_cmd(CMD_WRITE, 8'h00);
        send_cmd(CMD_WRITE, 8'hFF);
        read_line();
        wait_drain();
    endtask

    // mostly well-formed lines plus stray reads and raw bytes
    task automatic test_random_traffic(input int send_pct, input int sink_pct,
                                       input logic [BYTE_W-1:0] delim,
                                       input int n_items);
        int sent;
        int r;
        int len;
        set_delimiter(delim);
        send_idle_pct = send_pct;
        sink_stall_pct <= sink_pct;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                if ($urandom_range(24) == 0)
                    len = $urandom_range(40, 20);
                else
                    len = $urandom_range(8, 1);
                send_line(len);
                sent += len;
                if ($urandom_range(4) != 0)
                begin
                    read_line();
                    sent++;
                end
            end
            else if (r < 85)
            begin
                read_line();
                sent++;
            end
            else
            begin
                len = $urandom_range(4, 1);
                repeat (len) send_cmd(CMD_WRITE, BYTE_W'($urandom_range(255)));
                sent += len;
            end
        end
        wait_drain();
    endtask

    // output held off during a full-depth line so the input stalls
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        sink_stall_pct <= 0;
        // DEPTH writes leave exactly this line in the ring
        send_line(DEPTH);
        hold_requests <= hold_requests + 1;
        read_line();
        repeat (12) send_cmd(CMD_WRITE, plain_byte());
        read_line();
        wait_drain();
    endtask

    // overwrite past full: the early delimiter is dropped
    task automatic test_full_overwrite();
        send_idle_pct = 10;
        sink_stall_pct <= 20;
        send_cmd(CMD_WRITE, delim_reg);
        send_line(DEPTH);
        read_line();
        read_line();
        wait_drain();
    endtask

    // main sequence
    initial
    begin
        in_if.valid     = 1'b0;
        in_if.func      = CMD_WRITE;
        in_if.data_byte = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        rst_n           = 1'b0;
        rd_ptr          = 0;
        wr_ptr          = 0;
        fill_level      = 0;
        delim_reg       = DELIM_RESET;
        send_idle_pct   = 0;
        sink_stall_pct  = 0;
        hold_requests   = 0;
        mismatch_count  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_lines();
        test_delimiter_extremes();
        test_random_traffic(33, 55, 8'h00, 35);
        test_random_traffic(55, 33, 8'hFF, 35);
        test_random_traffic(0, 0, BYTE_W'($urandom_range(254, 1)), 35);
        test_output_backpressure();
        test_full_overwrite();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && line_words_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // output side: random stalls, plus the long hold-off on request
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_if.ready <= 1'b0;
                hold_left--;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_LEN - 1;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin
        line_word_t exp_w;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (line_words_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected word found=%b byte=%02h last=%b",
                             $realtime, out_if.found, out_if.out_byte, out_if.last);
            end
            else
            begin
                exp_w = line_words_q.pop_front();
                if (out_if.found !== exp_w.found || out_if.out_byte !== exp_w.byte_val
                    || out_if.last !== exp_w.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch exp found=%b byte=%02h last=%b, got %b %02h %b",
                                 $realtime, exp_w.found, exp_w.byte_val, exp_w.last,
                                 out_if.found, out_if.out_byte, out_if.last);
                end
            end
        end
    end

    // watchdog: cycles with no word moving on any channel
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                stall_cycles = 0;
            else if (rst_n)
                stall_cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

endmodule
